// ===== sv/graph_adjacency_bfs_path_macros.svh =====
// Assertion macros shared by the graph path block.
`ifndef GRAPH_ADJACENCY_BFS_PATH_MACROS_SVH
`define GRAPH_ADJACENCY_BFS_PATH_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GABP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define GABP_ASSERT_NEVER(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// ===== sv/gabp_pkg.sv =====
// Shared types, codes and constants of the graph path block.
package gabp_pkg;

  localparam int unsigned MAX_VERTICES_DFLT = 64;
  localparam int unsigned MAX_DEGREE_DFLT   = 64;

  localparam int unsigned VW    = 6;  // vertex index width
  localparam int unsigned CW    = 7;  // counts, degrees and scan indexes
  localparam int unsigned VAL_W = 8;

  localparam logic [VAL_W-1:0] NO_VERTEX = 8'hFF;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_REM  = 3'd1;
  localparam logic [2:0] CMD_DEG  = 3'd2;
  localparam logic [2:0] CMD_MAX  = 3'd3;
  localparam logic [2:0] CMD_PATH = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NO_PATH = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_RES_INV, OP_RES_OK, OP_RES_FULL, OP_RES_NOPATH,
    OP_RES_DEG, OP_RES_MAX, OP_RES_PATH, OP_PUSH_OUT,
    OP_RD_DEG_U, OP_LATCH_DU, OP_RD_NBR, OP_IDX_INC, OP_RD_DEG_W, OP_LATCH_DW,
    OP_WR_A, OP_WR_B, OP_RD_NBR_NEXT, OP_SH_WR, OP_DEC, OP_SWAP,
    OP_MX_INIT, OP_RD_DEG_IDX, OP_MX_CMP,
    OP_P_INIT, OP_RD_Q, OP_P_CUR, OP_P_VIS, OP_W_INIT, OP_W_PUSH, OP_W_NEXT,
    OP_RD_STK
  } gabp_op_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic       ok_a;
    logic       ok_b;
    logic       same_ab;
    logic       swap;
    logic       idx_eq_du;
    logic       nbr_eq_w;
    logic       full;
    logic       last_shift;
    logic       idx_eq_n;
    logic       q_empty;
    logic       cur_is_target;
    logic       target_visited;
    logic       v_is_start;
    logic       res_last;
    logic       out_free;
  } gabp_sts_t;

endpackage

// ===== sv/gabp_ctrl.sv =====
// Command sequencer: walks each command through its steps on the datapath.
module gabp_ctrl import gabp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gabp_sts_t sts_i,
  output gabp_op_e  op_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_A_LDU  = 5'd2;
  localparam logic [4:0] S_A_SCAN = 5'd3;
  localparam logic [4:0] S_A_CMP  = 5'd4;
  localparam logic [4:0] S_A_LDW  = 5'd5;
  localparam logic [4:0] S_A_CHK  = 5'd6;
  localparam logic [4:0] S_A_WRB  = 5'd7;
  localparam logic [4:0] S_A_DONE = 5'd8;
  localparam logic [4:0] S_R_LDU  = 5'd9;
  localparam logic [4:0] S_R_SCAN = 5'd10;
  localparam logic [4:0] S_R_CMP  = 5'd11;
  localparam logic [4:0] S_R_SHRD = 5'd12;
  localparam logic [4:0] S_R_SHWR = 5'd13;
  localparam logic [4:0] S_R_SIDE = 5'd14;
  localparam logic [4:0] S_R_RDU  = 5'd15;
  localparam logic [4:0] S_D_RES  = 5'd16;
  localparam logic [4:0] S_M_RD   = 5'd17;
  localparam logic [4:0] S_M_CMP  = 5'd18;
  localparam logic [4:0] S_P_DEQ  = 5'd19;
  localparam logic [4:0] S_P_CUR  = 5'd20;
  localparam logic [4:0] S_P_LDU  = 5'd21;
  localparam logic [4:0] S_P_NB   = 5'd22;
  localparam logic [4:0] S_P_VIS  = 5'd23;
  localparam logic [4:0] S_P_END  = 5'd24;
  localparam logic [4:0] S_W_PUSH = 5'd25;
  localparam logic [4:0] S_W_NEXT = 5'd26;
  localparam logic [4:0] S_O_RD   = 5'd27;
  localparam logic [4:0] S_O_SET  = 5'd28;
  localparam logic [4:0] S_EMIT   = 5'd29;

  logic [4:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.cmd)
          CMD_ADD, CMD_REM, CMD_PATH: begin
            if (!(sts_i.ok_a && sts_i.ok_b)) begin
              op_o    = OP_RES_INV;
              state_d = S_EMIT;
            end else if (sts_i.cmd == CMD_PATH) begin
              op_o    = OP_P_INIT;
              state_d = S_P_DEQ;
            end else begin
              op_o    = OP_RD_DEG_U;
              state_d = (sts_i.cmd == CMD_ADD) ? S_A_LDU : S_R_LDU;
            end
          end
          CMD_DEG: begin
            if (!sts_i.ok_a) begin
              op_o    = OP_RES_INV;
              state_d = S_EMIT;
            end else begin
              op_o    = OP_RD_DEG_U;
              state_d = S_D_RES;
            end
          end
          CMD_MAX: begin
            op_o    = OP_MX_INIT;
            state_d = S_M_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_A_LDU: begin
        op_o    = OP_LATCH_DU;
        state_d = S_A_SCAN;
      end
      S_A_SCAN: begin
        if (sts_i.idx_eq_du) begin
          op_o    = OP_RD_DEG_W;
          state_d = S_A_LDW;
        end else begin
          op_o    = OP_RD_NBR;
          state_d = S_A_CMP;
        end
      end
      S_A_CMP: begin
        if (sts_i.nbr_eq_w) begin
          op_o    = OP_RES_OK;
          state_d = S_EMIT;
        end else begin
          op_o    = OP_IDX_INC;
          state_d = S_A_SCAN;
        end
      end
      S_A_LDW: begin
        op_o    = OP_LATCH_DW;
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts_i.full) begin
          op_o    = OP_RES_FULL;
          state_d = S_EMIT;
        end else begin
          op_o    = OP_WR_A;
          state_d = S_A_WRB;
        end
      end
      S_A_WRB: begin
        if (sts_i.same_ab) begin
          op_o    = OP_RES_OK;
          state_d = S_EMIT;
        end else begin
          op_o    = OP_WR_B;
          state_d = S_A_DONE;
        end
      end
      S_A_DONE: begin
        op_o    = OP_RES_OK;
        state_d = S_EMIT;
      end
      S_R_LDU: begin
        op_o    = OP_LATCH_DU;
        state_d = S_R_SCAN;
      end
      S_R_SCAN: begin
        if (sts_i.idx_eq_du) begin
          state_d = S_R_SIDE;
        end else begin
          op_o    = OP_RD_NBR;
          state_d = S_R_CMP;
        end
      end
      S_R_CMP: begin
        if (sts_i.nbr_eq_w) begin
          state_d = S_R_SHRD;
        end else begin
          op_o    = OP_IDX_INC;
          state_d = S_R_SCAN;
        end
      end
      S_R_SHRD: begin
        if (sts_i.last_shift) begin
          op_o    = OP_DEC;
          state_d = S_R_SIDE;
        end else begin
          op_o    = OP_RD_NBR_NEXT;
          state_d = S_R_SHWR;
        end
      end
      S_R_SHWR: begin
        op_o    = OP_SH_WR;
        state_d = S_R_SHRD;
      end
      S_R_SIDE: begin
        if (!sts_i.swap && !sts_i.same_ab) begin
          op_o    = OP_SWAP;
          state_d = S_R_RDU;
        end else begin
          op_o    = OP_RES_OK;
          state_d = S_EMIT;
        end
      end
      S_R_RDU: begin
        op_o    = OP_RD_DEG_U;
        state_d = S_R_LDU;
      end
      S_D_RES: begin
        op_o    = OP_RES_DEG;
        state_d = S_EMIT;
      end
      S_M_RD: begin
        if (sts_i.idx_eq_n) begin
          op_o    = OP_RES_MAX;
          state_d = S_EMIT;
        end else begin
          op_o    = OP_RD_DEG_IDX;
          state_d = S_M_CMP;
        end
      end
      S_M_CMP: begin
        op_o    = OP_MX_CMP;
        state_d = S_M_RD;
      end
      S_P_DEQ: begin
        if (sts_i.q_empty) begin
          state_d = S_P_END;
        end else begin
          op_o    = OP_RD_Q;
          state_d = S_P_CUR;
        end
      end
      S_P_CUR: begin
        if (sts_i.cur_is_target) begin
          state_d = S_P_END;
        end else begin
          op_o    = OP_P_CUR;
          state_d = S_P_LDU;
        end
      end
      S_P_LDU: begin
        op_o    = OP_LATCH_DU;
        state_d = S_P_NB;
      end
      S_P_NB: begin
        if (sts_i.idx_eq_du) begin
          state_d = S_P_DEQ;
        end else begin
          op_o    = OP_RD_NBR;
          state_d = S_P_VIS;
        end
      end
      S_P_VIS: begin
        op_o    = OP_P_VIS;
        state_d = S_P_NB;
      end
      S_P_END: begin
        if (!sts_i.target_visited) begin
          op_o    = OP_RES_NOPATH;
          state_d = S_EMIT;
        end else begin
          op_o    = OP_W_INIT;
          state_d = S_W_PUSH;
        end
      end
      S_W_PUSH: begin
        op_o    = OP_W_PUSH;
        state_d = sts_i.v_is_start ? S_O_RD : S_W_NEXT;
      end
      S_W_NEXT: begin
        op_o    = OP_W_NEXT;
        state_d = S_W_PUSH;
      end
      S_O_RD: begin
        op_o    = OP_RD_STK;
        state_d = S_O_SET;
      end
      S_O_SET: begin
        op_o    = OP_RES_PATH;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          op_o    = OP_PUSH_OUT;
          state_d = sts_i.res_last ? S_IDLE : S_O_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/gabp_dp.sv =====
// Datapath: neighbor, degree, parent, queue and stack memories with scan registers.
module gabp_dp import gabp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DFLT,
  parameter int unsigned MAX_DEGREE   = MAX_DEGREE_DFLT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CW-1:0]    cfg_wdata_i,
  input  logic [2:0]       command_i,
  input  logic [VW-1:0]    vertex_a_i,
  input  logic [VW-1:0]    vertex_b_i,
  input  gabp_op_e         op_i,
  output gabp_sts_t        sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [VAL_W-1:0] value_o,
  output logic             last_o
);

  localparam int unsigned VA_W = $clog2(MAX_VERTICES);
  localparam int unsigned NA_W = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam logic [CW-1:0]   NV_C = CW'(MAX_VERTICES);
  localparam logic [CW-1:0]   ND_C = CW'(MAX_DEGREE);
  localparam logic [NA_W-1:0] ND_A = NA_W'(MAX_DEGREE);
  localparam logic [MAX_VERTICES-1:0] VIS_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  function automatic logic [NA_W-1:0] naddr(input logic [VW-1:0] v, input logic [CW-1:0] s);
    naddr = NA_W'(v[VA_W-1:0]) * ND_A + NA_W'(s);
  endfunction

  logic [CW-1:0]    cnt_q;
  logic [2:0]       cmd_q;
  logic [VW-1:0]    a_q, b_q, cur_q, v_q, best_q;
  logic             swap_q, best_vld_q;
  logic [CW-1:0]    idx_q, du_q, dw_q, head_q, tail_q, depth_q, best_deg_q;
  logic [1:0]       res_status_q;
  logic [VAL_W-1:0] res_value_q;
  logic             res_last_q;
  logic             out_valid_q;
  logic [1:0]       out_status_q;
  logic [VAL_W-1:0] out_value_q;
  logic             out_last_q;
  logic [MAX_VERTICES-1:0] visited_q, deg_vld_q;

  logic [VW-1:0] nbr_mem [MAX_VERTICES*MAX_DEGREE];
  logic [CW-1:0] deg_mem [MAX_VERTICES];
  logic [VW-1:0] par_mem [MAX_VERTICES];
  logic [VW-1:0] q_mem   [MAX_VERTICES];
  logic [VW-1:0] stk_mem [MAX_VERTICES];
  logic [VW-1:0] nbr_rd_q, par_rd_q, q_rd_q, stk_rd_q;
  logic [CW-1:0] deg_rd_q;
  logic          deg_rd_vld_q;

  logic            nbr_we, nbr_re, deg_we, deg_re, par_we, par_re;
  logic            q_we, q_re, stk_we, stk_re;
  logic [NA_W-1:0] nbr_wa, nbr_ra;
  logic [VW-1:0]   nbr_wd, par_wd, q_wd, stk_wd;
  logic [VA_W-1:0] deg_wa, deg_ra, par_wa, par_ra, q_wa, q_ra, stk_wa, stk_ra;
  logic [CW-1:0]   deg_wd;

  logic [CW-1:0] n_c, deg_rd_c, idx_p1, depth_m1;
  logic [VW-1:0] u_c, w_c;
  logic          visit_c;

  assign n_c      = (cnt_q > NV_C) ? NV_C : cnt_q;
  assign u_c      = (cmd_q == CMD_PATH) ? cur_q : (swap_q ? b_q : a_q);
  assign w_c      = swap_q ? a_q : b_q;
  assign deg_rd_c = deg_rd_vld_q ? deg_rd_q : '0;
  assign idx_p1   = idx_q + CW'(1);
  assign depth_m1 = depth_q - CW'(1);
  // A neighbor joins the search only the first time it is seen.
  assign visit_c  = ({1'b0, nbr_rd_q} < NV_C) && !visited_q[nbr_rd_q[VA_W-1:0]]
                    && (tail_q < NV_C);

  always_comb begin
    nbr_we = 1'b0; nbr_re = 1'b0; nbr_wa = '0; nbr_ra = '0; nbr_wd = '0;
    deg_we = 1'b0; deg_re = 1'b0; deg_wa = '0; deg_ra = '0; deg_wd = '0;
    par_we = 1'b0; par_re = 1'b0; par_wa = '0; par_ra = '0; par_wd = '0;
    q_we   = 1'b0; q_re   = 1'b0; q_wa   = '0; q_ra   = '0; q_wd   = '0;
    stk_we = 1'b0; stk_re = 1'b0; stk_wa = '0; stk_ra = '0; stk_wd = '0;
    unique case (op_i)
      OP_RD_NBR: begin
        nbr_re = 1'b1;
        nbr_ra = naddr(u_c, idx_q);
      end
      OP_RD_NBR_NEXT: begin
        nbr_re = 1'b1;
        nbr_ra = naddr(u_c, idx_p1);
      end
      OP_SH_WR: begin
        nbr_we = 1'b1;
        nbr_wa = naddr(u_c, idx_q);
        nbr_wd = nbr_rd_q;
      end
      OP_WR_A: begin
        nbr_we = 1'b1;
        nbr_wa = naddr(u_c, du_q);
        nbr_wd = w_c;
        deg_we = 1'b1;
        deg_wa = u_c[VA_W-1:0];
        deg_wd = du_q + CW'(1);
      end
      OP_WR_B: begin
        nbr_we = 1'b1;
        nbr_wa = naddr(w_c, dw_q);
        nbr_wd = u_c;
        deg_we = 1'b1;
        deg_wa = w_c[VA_W-1:0];
        deg_wd = dw_q + CW'(1);
      end
      OP_DEC: begin
        deg_we = 1'b1;
        deg_wa = u_c[VA_W-1:0];
        deg_wd = du_q - CW'(1);
      end
      OP_RD_DEG_U: begin
        deg_re = 1'b1;
        deg_ra = u_c[VA_W-1:0];
      end
      OP_RD_DEG_W: begin
        deg_re = 1'b1;
        deg_ra = w_c[VA_W-1:0];
      end
      OP_RD_DEG_IDX: begin
        deg_re = 1'b1;
        deg_ra = idx_q[VA_W-1:0];
      end
      OP_P_INIT: begin
        q_we = 1'b1;
        q_wa = '0;
        q_wd = a_q;
      end
      OP_RD_Q: begin
        q_re = 1'b1;
        q_ra = head_q[VA_W-1:0];
      end
      OP_P_CUR: begin
        deg_re = 1'b1;
        deg_ra = q_rd_q[VA_W-1:0];
      end
      OP_P_VIS: begin
        par_we = visit_c;
        par_wa = nbr_rd_q[VA_W-1:0];
        par_wd = cur_q;
        q_we   = visit_c;
        q_wa   = tail_q[VA_W-1:0];
        q_wd   = nbr_rd_q;
      end
      OP_W_PUSH: begin
        par_re = 1'b1;
        par_ra = v_q[VA_W-1:0];
        stk_we = 1'b1;
        stk_wa = depth_q[VA_W-1:0];
        stk_wd = v_q;
      end
      OP_RD_STK: begin
        stk_re = 1'b1;
        stk_ra = depth_m1[VA_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    if (nbr_re) nbr_rd_q <= nbr_mem[nbr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    if (deg_re) deg_rd_q <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    if (par_re) par_rd_q <= par_mem[par_ra];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_rd_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd_q <= stk_mem[stk_ra];
  end

  // Degree entries without a valid bit read as zero; a count write drops them all.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      deg_vld_q    <= '0;
      deg_rd_vld_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cnt_q     <= cfg_wdata_i;
        deg_vld_q <= '0;
      end else if (deg_we) begin
        deg_vld_q[deg_wa] <= 1'b1;
      end
      if (deg_re) deg_rd_vld_q <= deg_vld_q[deg_ra];
      if (op_i == OP_PUSH_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0; a_q <= '0; b_q <= '0; cur_q <= '0; v_q <= '0; best_q <= '0;
      swap_q <= 1'b0; best_vld_q <= 1'b0;
      idx_q <= '0; du_q <= '0; dw_q <= '0; head_q <= '0; tail_q <= '0;
      depth_q <= '0; best_deg_q <= '0;
      visited_q <= '0;
      res_status_q <= ST_OK; res_value_q <= NO_VERTEX; res_last_q <= 1'b1;
    end else begin
      unique case (op_i)
        OP_LOAD: begin
          cmd_q  <= command_i;
          a_q    <= vertex_a_i;
          b_q    <= vertex_b_i;
          swap_q <= 1'b0;
        end
        OP_RES_INV: begin
          res_status_q <= ST_INVALID;
          res_value_q  <= (cmd_q == CMD_DEG) ? '0 : NO_VERTEX;
          res_last_q   <= 1'b1;
        end
        OP_RES_OK: begin
          res_status_q <= ST_OK;
          res_value_q  <= NO_VERTEX;
          res_last_q   <= 1'b1;
        end
        OP_RES_FULL: begin
          res_status_q <= ST_FULL;
          res_value_q  <= NO_VERTEX;
          res_last_q   <= 1'b1;
        end
        OP_RES_NOPATH: begin
          res_status_q <= ST_NO_PATH;
          res_value_q  <= NO_VERTEX;
          res_last_q   <= 1'b1;
        end
        OP_RES_DEG: begin
          res_status_q <= ST_OK;
          res_value_q  <= {1'b0, deg_rd_c};
          res_last_q   <= 1'b1;
        end
        OP_RES_MAX: begin
          res_status_q <= ST_OK;
          res_value_q  <= best_vld_q ? {2'b00, best_q} : NO_VERTEX;
          res_last_q   <= 1'b1;
        end
        OP_RES_PATH: begin
          res_status_q <= ST_OK;
          res_value_q  <= {2'b00, stk_rd_q};
          res_last_q   <= (depth_q == '0);
        end
        OP_LATCH_DU: begin
          du_q  <= deg_rd_c;
          idx_q <= '0;
        end
        OP_LATCH_DW: dw_q <= deg_rd_c;
        OP_IDX_INC, OP_SH_WR: idx_q <= idx_p1;
        OP_SWAP: swap_q <= 1'b1;
        OP_MX_INIT: begin
          idx_q      <= '0;
          best_vld_q <= 1'b0;
        end
        OP_MX_CMP: begin
          if (!best_vld_q || (deg_rd_c > best_deg_q)) begin
            best_q     <= idx_q[VW-1:0];
            best_deg_q <= deg_rd_c;
            best_vld_q <= 1'b1;
          end
          idx_q <= idx_p1;
        end
        OP_P_INIT: begin
          // Only the start vertex is marked when a search begins.
          visited_q <= VIS_ONE << a_q[VA_W-1:0];
          head_q    <= '0;
          tail_q    <= CW'(1);
        end
        OP_P_CUR: begin
          cur_q  <= q_rd_q;
          head_q <= head_q + CW'(1);
        end
        OP_P_VIS: begin
          if (visit_c) begin
            visited_q[nbr_rd_q[VA_W-1:0]] <= 1'b1;
            tail_q                        <= tail_q + CW'(1);
          end
          idx_q <= idx_p1;
        end
        OP_W_INIT: begin
          v_q     <= b_q;
          depth_q <= '0;
        end
        OP_W_PUSH: depth_q <= depth_q + CW'(1);
        OP_W_NEXT: v_q <= par_rd_q;
        OP_RD_STK: depth_q <= depth_m1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_PUSH_OUT) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_last_q   <= res_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

  always_comb begin
    sts_o.cmd            = cmd_q;
    sts_o.ok_a           = {1'b0, a_q} < n_c;
    sts_o.ok_b           = {1'b0, b_q} < n_c;
    sts_o.same_ab        = (a_q == b_q);
    sts_o.swap           = swap_q;
    sts_o.idx_eq_du      = (idx_q == du_q);
    sts_o.nbr_eq_w       = (nbr_rd_q == w_c);
    sts_o.full           = (du_q >= ND_C) || ((a_q != b_q) && (dw_q >= ND_C));
    sts_o.last_shift     = (idx_p1 >= du_q);
    sts_o.idx_eq_n       = (idx_q == n_c);
    sts_o.q_empty        = (head_q == tail_q);
    sts_o.cur_is_target  = (q_rd_q == b_q);
    sts_o.target_visited = visited_q[b_q[VA_W-1:0]];
    sts_o.v_is_start     = (v_q == a_q);
    sts_o.res_last       = res_last_q;
    sts_o.out_free       = !out_valid_q || out_ready_i;
  end

endmodule

// ===== sv/graph_adjacency_bfs_path.sv =====
// Undirected graph store with neighbor-list edits and breadth-first shortest path.
// Input channel: in_valid_i/in_ready_o carry command_i, vertex_a_i and vertex_b_i.
// Output channel: out_valid_o/out_ready_i carry status_o, value_o and last_o;
// last_o marks the final result of a command. One command is processed at a time.
// Configuration: cfg_we_i writes cfg_wdata_i into vertex_count and drops all edges.
// A shortest path runs the breadth-first search, then a parent walk back from the
// target that stacks the path, then emits the path vertices from the stack; the
// search dominates, since its neighbor scan reads one neighbor memory entry at a time.
// The result sits in an output register, so the last result of a command waits
// there while the next command is taken; a stalled receiver holds the sequencer
// whenever another result is ready while that register is still occupied.
// Reset clears the vertex count, all degrees and the output valid flag; neighbor
// storage needs no clearing pass since only entries below a degree are read.
module graph_adjacency_bfs_path import gabp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DFLT,
  parameter int unsigned MAX_DEGREE   = MAX_DEGREE_DFLT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CW-1:0]    cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       command_i,
  input  logic [VW-1:0]    vertex_a_i,
  input  logic [VW-1:0]    vertex_b_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [VAL_W-1:0] value_o,
  output logic             last_o
);

  `include "graph_adjacency_bfs_path_macros.svh"

  gabp_sts_t sts;
  gabp_op_e  op;

  gabp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  gabp_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .command_i   (command_i),
    .vertex_a_i  (vertex_a_i),
    .vertex_b_i  (vertex_b_i),
    .op_i        (op),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  `GABP_ASSERT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while a command is in progress")
  `GABP_ASSERT(a_push_into_free_slot, clk_i, rst_ni, op == OP_PUSH_OUT |-> sts.out_free, "result overwrote a waiting result")
  `GABP_ASSERT_NEVER(a_error_is_final, clk_i, rst_ni, out_valid_o && status_o != ST_OK && !last_o, "error result not marked last")

endmodule

// ===== bench/graph_adjacency_bfs_path_checker.sv =====
// Checker for the graph path block: tracks the graph, predicts results and compares them.
module graph_adjacency_bfs_path_checker import gabp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CW-1:0]    cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [2:0]       command_i,
  input  logic [VW-1:0]    vertex_a_i,
  input  logic [VW-1:0]    vertex_b_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [1:0]       status_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic             last_i,
  output int               err_cnt_o,
  output int               pending_o,
  output int               cmd_cnt_o,
  output int               res_cnt_o,
  output int               path_res_cnt_o
);

  localparam int NV = 64;
  localparam int ND = 64;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
    logic             last;
  } graph_result_t;

  graph_result_t    result_fifo[$];
  logic [CW-1:0]    vcount_q;
  logic [CW-1:0]    degree_q[NV];
  logic [VW-1:0]    adj_mem[NV][ND];

  assign pending_o = result_fifo.size();

  task automatic report(input string what, input graph_result_t got, input graph_result_t exp);
    err_cnt_o++;
    if (err_cnt_o <= 20)
      $display("mismatch (%s): got st=%0d val=%0d last=%0d, exp st=%0d val=%0d last=%0d",
               what, got.status, $signed(got.value), got.last,
               exp.status, $signed(exp.value), exp.last);
  endtask

  task automatic push_result(input logic [1:0] st, input int val, input logic lst);
    graph_result_t r;
    r.status = st;
    r.value  = VAL_W'(val);
    r.last   = lst;
    result_fifo.push_back(r);
  endtask

  function automatic bit is_neighbor(input int u, input int v);
    for (int i = 0; i < degree_q[u]; i++)
      if (adj_mem[u][i] == VW'(v)) return 1'b1;
    return 1'b0;
  endfunction

  task automatic unlink(input int u, input int v);
    int n;
    n = degree_q[u];
    for (int i = 0; i < n; i++) begin
      if (adj_mem[u][i] == VW'(v)) begin
        for (int j = i; j + 1 < n; j++) adj_mem[u][j] = adj_mem[u][j+1];
        degree_q[u] = CW'(n - 1);
        return;
      end
    end
  endtask

  task automatic link(input int a, input int b);
    bit need_a, need_b;
    need_a = !is_neighbor(a, b);
    need_b = (a != b) && !is_neighbor(b, a);
    if ((need_a && degree_q[a] >= ND) || (need_b && degree_q[b] >= ND)) begin
      push_result(ST_FULL, -1, 1'b1);
      return;
    end
    if (need_a) begin
      adj_mem[a][degree_q[a]] = VW'(b);
      degree_q[a]++;
    end
    if (need_b) begin
      adj_mem[b][degree_q[b]] = VW'(a);
      degree_q[b]++;
    end
    push_result(ST_OK, -1, 1'b1);
  endtask

  // Breadth-first search in list order, then a parent walk back from the target.
  task automatic predict_path(input int start, input int target, input int n);
    bit seen[NV];
    int parent[NV];
    int fifo[NV];
    int stk[NV];
    int head, tail, cur, nb, v, depth;
    for (int i = 0; i < NV; i++) begin
      seen[i] = 1'b0;
      parent[i] = -1;
    end
    head = 0;
    tail = 0;
    depth = 0;
    seen[start] = 1'b1;
    fifo[tail++] = start;
    while (head < tail) begin
      cur = fifo[head++];
      if (cur == target) break;
      for (int i = 0; i < degree_q[cur]; i++) begin
        nb = adj_mem[cur][i];
        if (!seen[nb] && tail < NV) begin
          seen[nb] = 1'b1;
          parent[nb] = cur;
          fifo[tail++] = nb;
        end
      end
    end
    if (!seen[target]) begin
      push_result(ST_NO_PATH, -1, 1'b1);
      return;
    end
    v = target;
    while (v != -1 && depth < n) begin
      stk[depth++] = v;
      v = parent[v];
    end
    while (depth > 0) begin
      depth--;
      push_result(ST_OK, stk[depth], depth == 0);
      path_res_cnt_o++;
    end
  endtask

  task automatic predict_command(input logic [2:0] cmd, input int a, input int b);
    int n, best, best_deg;
    n = (vcount_q > NV) ? NV : int'(vcount_q);
    cmd_cnt_o++;
    case (cmd)
      CMD_ADD: begin
        if (a >= n || b >= n) push_result(ST_INVALID, -1, 1'b1);
        else link(a, b);
      end
      CMD_REM: begin
        if (a >= n || b >= n) push_result(ST_INVALID, -1, 1'b1);
        else begin
          unlink(a, b);
          if (a != b) unlink(b, a);
          push_result(ST_OK, -1, 1'b1);
        end
      end
      CMD_DEG: begin
        if (a >= n) push_result(ST_INVALID, 0, 1'b1);
        else push_result(ST_OK, degree_q[a], 1'b1);
      end
      CMD_MAX: begin
        best = -1;
        best_deg = -1;
        for (int i = 0; i < n; i++) begin
          if (int'(degree_q[i]) > best_deg) begin
            best_deg = degree_q[i];
            best = i;
          end
        end
        push_result(ST_OK, best, 1'b1);
      end
      CMD_PATH: begin
        if (a >= n || b >= n) push_result(ST_INVALID, -1, 1'b1);
        else predict_path(a, b, n);
      end
      default: cmd_cnt_o--;  // spare codes are dropped by the block
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    graph_result_t got, exp;
    if (!rst_ni) begin
      vcount_q = '0;
      for (int i = 0; i < NV; i++) degree_q[i] = '0;
      result_fifo.delete();
      err_cnt_o = 0;
      cmd_cnt_o = 0;
      res_cnt_o = 0;
      path_res_cnt_o = 0;
    end else begin
      // A result seen now was caused by an earlier transfer, so compare first.
      if (out_valid_i && out_ready_i) begin
        got.status = status_i;
        got.value  = value_i;
        got.last   = last_i;
        res_cnt_o++;
        if (result_fifo.size() == 0) begin
          exp = '0;
          report("unexpected result", got, exp);
        end else begin
          exp = result_fifo.pop_front();
          if (got.status != exp.status) report("status", got, exp);
          if (got.value != exp.value) report("value", got, exp);
          if (got.last != exp.last) report("last", got, exp);
        end
      end
      if (cfg_we_i) begin
        vcount_q = cfg_wdata_i;
        for (int i = 0; i < NV; i++) degree_q[i] = '0;
      end
      if (in_valid_i && in_ready_i)
        predict_command(command_i, vertex_a_i, vertex_b_i);
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the graph path block: stimulus, flow control and verdict.
module tb;
  import gabp_pkg::*;

  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int STALL_LIMIT = 40000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CW-1:0]    cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [2:0]       command_i;
  logic [VW-1:0]    vertex_a_i;
  logic [VW-1:0]    vertex_b_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [1:0]       status_o;
  logic [VAL_W-1:0] value_o;
  logic             last_o;

  int err_cnt, pending, cmd_cnt, res_cnt, path_res_cnt;
  int burst_left;
  int cfg_writes;
  bit hold_req;

  graph_adjacency_bfs_path u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .command_i, .vertex_a_i, .vertex_b_i, .out_valid_o, .out_ready_i,
    .status_o, .value_o, .last_o
  );

  graph_adjacency_bfs_path_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .command_i, .vertex_a_i, .vertex_b_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .value_i(value_o), .last_i(last_o), .err_cnt_o(err_cnt),
    .pending_o(pending), .cmd_cnt_o(cmd_cnt), .res_cnt_o(res_cnt),
    .path_res_cnt_o(path_res_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: windows of free flow or random stalls, chosen at random, plus one long hold-off.
  initial begin
    int span;
    bit choppy;
    out_ready_i = 1'b0;
    span = 0;
    choppy = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (500) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        if (span == 0) begin
          span = $urandom_range(16, 96);
          choppy = $urandom_range(0, 2) != 0;
        end
        span--;
        out_ready_i <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic issue(input logic [2:0] cmd, input int a, input int b);
    int gap;
    logic rdy;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    vertex_a_i <= VW'(a);
    vertex_b_i <= VW'(b);
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    // Spare codes give no result, so allow the block time to settle.
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input int n);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CW'(n);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic random_phase(input int vc, input int count);
    int n, pick, a, b;
    n = (vc > 64) ? 64 : vc;
    set_vertex_count(vc);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      a = (n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
      b = (n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
      if (pick < 45) issue(CMD_ADD, a, b);
      else if (pick < 60) issue(CMD_REM, a, b);
      else if (pick < 70) issue(CMD_DEG, a, b);
      else if (pick < 77) issue(CMD_MAX, a, b);
      else if (pick < 97) issue(CMD_PATH, a, b);
      else issue(3'($urandom_range(5, 7)), a, b);
    end
  endtask

  initial begin
    int order[63];
    int j, tmp;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    command_i   = '0;
    vertex_a_i  = '0;
    vertex_b_i  = '0;
    burst_left  = 0;
    cfg_writes  = 0;
    hold_req    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No vertices in use: everything is invalid and max degree has no answer; then one vertex.
    issue(CMD_MAX, 0, 0);
    issue(CMD_DEG, 0, 0);
    issue(CMD_PATH, 0, 0);
    set_vertex_count(1);
    issue(CMD_PATH, 0, 0);
    issue(CMD_ADD, 0, 0);
    issue(CMD_DEG, 0, 0);

    // Small graph: duplicates, self loop, removal, unreachable target, spare codes.
    set_vertex_count(6);
    issue(CMD_ADD, 0, 1);
    issue(CMD_ADD, 1, 2);
    issue(CMD_ADD, 1, 0);
    issue(CMD_ADD, 2, 2);
    issue(CMD_PATH, 0, 2);
    issue(CMD_PATH, 2, 0);
    issue(CMD_PATH, 0, 4);
    issue(CMD_DEG, 2, 0);
    issue(CMD_MAX, 0, 0);
    issue(CMD_REM, 1, 2);
    issue(CMD_PATH, 0, 2);
    issue(CMD_REM, 3, 4);
    issue(CMD_ADD, 63, 0);
    issue(CMD_REM, 0, 63);
    issue(CMD_DEG, 63, 63);
    issue(CMD_PATH, 5, 63);
    issue(CMD_SPARE5, 63, 63);
    issue(CMD_SPARE6, 0, 0);
    issue(CMD_SPARE7, 42, 21);

    // Full-size chain, built in random order while the receiver holds off.
    set_vertex_count(64);
    for (int i = 0; i < 63; i++) order[i] = i;
    for (int i = 62; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    hold_req = 1'b1;
    for (int i = 0; i < 63; i++) issue(CMD_ADD, order[i] + 1, order[i]);
    issue(CMD_PATH, 0, 63);
    issue(CMD_PATH, 63, 0);
    issue(CMD_DEG, 31, 0);
    issue(CMD_MAX, 0, 0);

    random_phase(5, 10);
    random_phase(10, 12);
    random_phase(127, 10);
    random_phase(65, 6);
    random_phase(3, 10);

    drain();
    $display("Covered %0d commands and %0d results (%0d path vertices) over %0d vertex counts.",
             cmd_cnt, res_cnt, path_res_cnt, cfg_writes);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
